FILE: design/bft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bidirectional flow table package
// Shared types, codes and defaults for the flow table block.
// ----------------------------------------------------------------------------
package bft_pkg;

  localparam int DEF_FLOW_ENTRIES = 64;
  localparam int DEF_COUNT_BITS   = 16;

  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 112;

  // Result status codes.
  localparam logic [1:0] STATUS_HIT  = 2'd0;
  localparam logic [1:0] STATUS_NEW  = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  // One packet header as held in the queue.
  typedef struct packed {
    logic        tcp;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] time_sec;
    logic [19:0] time_usec;
  } pkt_t;

  // Queue handshake toward the back end.
  typedef struct packed {
    logic valid;
    pkt_t pkt;
  } q_head_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MATCH,
    BK_FIND,
    BK_UPDATE
  } back_state_t;

endpackage

FILE: design/bidirectional_flow_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bidirectional flow table
// Looks up packets in a table of four-tuple flows, either direction, and
// keeps per-flow packet, forward and backward counts.
// ----------------------------------------------------------------------------
//  Channel | Direction | Beat contents
//  in_     | slave     | tuser: mode; tdata: packet tuple and capture time
//  out_    | master    | tuser: status; tdata: slot, direction, counts, start
//
// Each packet passes through the back end in order: a load from the queue, a
// parallel compare over all flow keys, a priority pick of the first match
// that also issues the registered reads of the counter and start-time
// memories, then the update and write-back. Reset is synchronous and empties
// the table at once. A waiting result holds the back end in its update state;
// a two-beat queue keeps input flowing meanwhile.
// ----------------------------------------------------------------------------
module bidirectional_flow_table #(
  parameter int FLOW_ENTRIES = bft_pkg::DEF_FLOW_ENTRIES,
  parameter int COUNT_BITS   = bft_pkg::DEF_COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // source_address, dest_address, source_port, dest_port, time_sec, time_usec
  input  logic [bft_pkg::IN_DATA_W-1:0] in_tdata,
  // mode
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // flow_slot, is_backward, flow_packets, forward_packets, backward_packets,
  // first_sec, first_usec, entry_is_tcp
  output logic [bft_pkg::OUT_DATA_W-1:0] out_tdata,
  // status
  output logic [1:0]                    out_tuser
);
  import bft_pkg::*;

  q_head_t head;
  logic    pop;

  bft_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .head      (head),
    .pop       (pop)
  );

  bft_back #(
    .FLOW_ENTRIES (FLOW_ENTRIES),
    .COUNT_BITS   (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: design/bft_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/bft_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow table front end
// Accepts packet beats, unpacks them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module bft_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [bft_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                    in_tuser,
  output bft_pkg::q_head_t        head,
  input  logic                    pop
);
  import bft_pkg::*;

  pkt_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       do_pop;
  pkt_t       in_pkt;

  // Unpack the incoming beat.
  always_comb begin
    in_pkt.tcp       = in_tuser;
    in_pkt.src_addr  = in_tdata[31:0];
    in_pkt.dst_addr  = in_tdata[63:32];
    in_pkt.sport     = in_tdata[79:64];
    in_pkt.dport     = in_tdata[95:80];
    in_pkt.time_sec  = in_tdata[127:96];
    in_pkt.time_usec = in_tdata[147:128];
  end

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign do_pop    = pop && (count_r != 2'd0);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_pkt;
    end
  end

  assign head.valid = (count_r != 2'd0);
  assign head.pkt   = slot_r[rd_ptr_r];

endmodule

FILE: design/bft_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow table back end
// Matches a packet against all flows in parallel, updates the counters and
// drives the result register.
// ----------------------------------------------------------------------------
module bft_back #(
  parameter int FLOW_ENTRIES = bft_pkg::DEF_FLOW_ENTRIES,
  parameter int COUNT_BITS   = bft_pkg::DEF_COUNT_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bft_pkg::q_head_t         head,
  output logic                     pop,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [bft_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]               out_tuser
);
  import bft_pkg::*;

  localparam int SLOT_W = $clog2(FLOW_ENTRIES);
  localparam int USED_W = $clog2(FLOW_ENTRIES + 1);
  localparam int CW     = COUNT_BITS;
  localparam int META_W = 53;

  back_state_t state_r, state_nxt;

  // Flow keys live in flip-flops so that every entry is compared at once.
  logic [31:0] key_sa_r [FLOW_ENTRIES];
  logic [31:0] key_da_r [FLOW_ENTRIES];
  logic [15:0] key_sp_r [FLOW_ENTRIES];
  logic [15:0] key_dp_r [FLOW_ENTRIES];

  logic [USED_W-1:0]       used_r;
  pkt_t                    pkt_r;
  logic [FLOW_ENTRIES-1:0] valid_vec;
  logic [FLOW_ENTRIES-1:0] match_vec;
  logic [FLOW_ENTRIES-1:0] hit_vec_r;
  logic                    enc_hit;
  logic [SLOT_W-1:0]       enc_slot;
  logic                    hit_r;
  logic [SLOT_W-1:0]       slot_r;
  logic                    full;
  logic                    finish;
  logic                    load_pkt;

  logic [SLOT_W-1:0]  ram_raddr;
  logic [SLOT_W-1:0]  ram_waddr;
  logic               cnt_we;
  logic [3*CW-1:0]    cnt_wdata;
  logic [3*CW-1:0]    cnt_rdata;
  logic               meta_we;
  logic [META_W-1:0]  meta_wdata;
  logic [META_W-1:0]  meta_rdata;

  logic [CW-1:0] pk_cur, fw_cur, bw_cur;
  logic [CW-1:0] pk_new, fw_new, bw_new;
  logic          back_dir;

  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;
  logic [1:0]            out_status_nxt;

  assign full = (used_r == USED_W'(FLOW_ENTRIES));

  // Parallel match in either direction against the used entries.
  always_comb begin
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      valid_vec[i] = (i < int'(used_r));
      match_vec[i] = valid_vec[i] && (
        (key_sa_r[i] == pkt_r.src_addr && key_da_r[i] == pkt_r.dst_addr &&
         key_sp_r[i] == pkt_r.sport && key_dp_r[i] == pkt_r.dport) ||
        (key_sa_r[i] == pkt_r.dst_addr && key_da_r[i] == pkt_r.src_addr &&
         key_sp_r[i] == pkt_r.dport && key_dp_r[i] == pkt_r.sport));
    end
  end

  // Lowest matching entry wins.
  always_comb begin
    enc_hit  = 1'b0;
    enc_slot = '0;
    for (int i = FLOW_ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec_r[i]) begin
        enc_hit  = 1'b1;
        enc_slot = SLOT_W'(i);
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:   if (head.valid) state_nxt = BK_MATCH;
      BK_MATCH:  state_nxt = BK_FIND;
      BK_FIND:   state_nxt = BK_UPDATE;
      BK_UPDATE: if (!out_valid_r || out_tready) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    load_pkt = 1'b0;
    finish   = 1'b0;
    unique case (state_r)
      BK_IDLE:   load_pkt = head.valid;
      BK_UPDATE: finish   = !out_valid_r || out_tready;
      default: begin
        load_pkt = 1'b0;
        finish   = 1'b0;
      end
    endcase
  end

  assign pop = load_pkt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Packet, match vector and chosen slot.
  always_ff @(posedge clk) begin
    if (load_pkt) begin
      pkt_r <= head.pkt;
    end
    if (state_r == BK_MATCH) begin
      hit_vec_r <= match_vec;
    end
    if (state_r == BK_FIND) begin
      hit_r  <= enc_hit;
      slot_r <= enc_slot;
    end
  end

  // Counter and start-time memories, read at the chosen slot.
  assign ram_raddr = (state_r == BK_FIND) ? enc_slot : slot_r;
  assign ram_waddr = hit_r ? slot_r : used_r[SLOT_W-1:0];

  bft_ram #(.WIDTH(3 * CW), .DEPTH(FLOW_ENTRIES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (ram_waddr),
    .wdata (cnt_wdata),
    .raddr (ram_raddr),
    .rdata (cnt_rdata)
  );

  bft_ram #(.WIDTH(META_W), .DEPTH(FLOW_ENTRIES)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (ram_waddr),
    .wdata (meta_wdata),
    .raddr (ram_raddr),
    .rdata (meta_rdata)
  );

  // Counter update with saturation.
  always_comb begin
    pk_cur   = cnt_rdata[CW-1:0];
    fw_cur   = cnt_rdata[2*CW-1:CW];
    bw_cur   = cnt_rdata[3*CW-1:2*CW];
    back_dir = key_sa_r[slot_r] != pkt_r.src_addr;
    pk_new   = pk_cur;
    fw_new   = fw_cur;
    bw_new   = bw_cur;
    if (hit_r) begin
      pk_new = (pk_cur == '1) ? pk_cur : pk_cur + CW'(1);
      if (pkt_r.tcp && back_dir) begin
        bw_new = (bw_cur == '1) ? bw_cur : bw_cur + CW'(1);
      end else if (pkt_r.tcp) begin
        fw_new = (fw_cur == '1) ? fw_cur : fw_cur + CW'(1);
      end
    end else begin
      pk_new = CW'(1);
      fw_new = CW'(1);
      bw_new = '0;
    end
    cnt_wdata  = {bw_new, fw_new, pk_new};
    meta_wdata = {pkt_r.tcp, pkt_r.time_usec, pkt_r.time_sec};
    cnt_we     = finish && (hit_r || !full);
    meta_we    = finish && !hit_r && !full;
  end

  // Result beat assembly.
  always_comb begin
    out_data_nxt   = '0;
    out_status_nxt = STATUS_FULL;
    if (hit_r) begin
      out_status_nxt = STATUS_HIT;
      out_data_nxt   = {4'd0, meta_rdata[52], meta_rdata[51:32], meta_rdata[31:0],
                        16'(bw_new), 16'(fw_new), 16'(pk_new), back_dir,
                        6'(slot_r)};
    end else if (!full) begin
      out_status_nxt = STATUS_NEW;
      out_data_nxt   = {4'd0, pkt_r.tcp, pkt_r.time_usec, pkt_r.time_sec,
                        16'(bw_new), 16'(fw_new), 16'(pk_new), 1'b0,
                        6'(used_r[SLOT_W-1:0])};
    end
  end

  // New flow keys and fill count.
  always_ff @(posedge clk) begin
    if (meta_we) begin
      key_sa_r[used_r[SLOT_W-1:0]] <= pkt_r.src_addr;
      key_da_r[used_r[SLOT_W-1:0]] <= pkt_r.dst_addr;
      key_sp_r[used_r[SLOT_W-1:0]] <= pkt_r.sport;
      key_dp_r[used_r[SLOT_W-1:0]] <= pkt_r.dport;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (meta_we) begin
      used_r <= used_r + USED_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(FLOW_ENTRIES))
    else $error("flow count beyond table size");

  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r == $past(used_r)) || (used_r == $past(used_r) + USED_W'(1)))
    else $error("flow count jumped");

  a_hits_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_FIND) |-> ((hit_vec_r & ~valid_vec) == '0))
    else $error("match on an unused entry");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == BK_UPDATE))
    else $error("result without an update");
`endif

endmodule

FILE: bench/tb_bidirectional_flow_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow table testbench
// Sends packet headers into the flow table and checks every result beat
// against a local model of the table. The model covers matches in both
// directions, new entries, a full table and repeated hits on one flow. Both
// sides of the stream idle at random.
// ----------------------------------------------------------------------------
module tb_bidirectional_flow_table;
  import bft_pkg::*;

  localparam int ENTRIES = DEF_FLOW_ENTRIES;
  localparam int CMAX    = (1 << DEF_COUNT_BITS) - 1;

  // One result beat, split into its fields.
  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic        back;
    logic [15:0] pkts;
    logic [15:0] fwd;
    logic [15:0] bwd;
    logic [31:0] first_sec;
    logic [19:0] first_usec;
    logic        is_tcp;
  } lookup_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;

  bidirectional_flow_table uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model of the flow table.
  pkt_t    tbl_key[ENTRIES];
  int      tbl_pkts[ENTRIES], tbl_fwd[ENTRIES], tbl_bwd[ENTRIES];
  int      tbl_used = 0;
  pkt_t    send_q[$];
  lookup_t expected_q[$];
  int      errors = 0;
  int      results_seen = 0;
  int      full_seen = 0;
  int      hits_seen = 0;
  bit      calm = 1'b0;
  bit      hold_input = 1'b0;
  bit      stim_done = 1'b0;

  function automatic int sat_inc(int v);
    return (v >= CMAX) ? CMAX : v + 1;
  endfunction

  function automatic lookup_t flow_lookup(pkt_t p);
    lookup_t r;
    int slot;
    slot = -1;
    r = '0;
    for (int i = 0; i < tbl_used; i++) begin
      if ((tbl_key[i].src_addr == p.src_addr && tbl_key[i].dst_addr == p.dst_addr &&
           tbl_key[i].sport == p.sport && tbl_key[i].dport == p.dport) ||
          (tbl_key[i].src_addr == p.dst_addr && tbl_key[i].dst_addr == p.src_addr &&
           tbl_key[i].sport == p.dport && tbl_key[i].dport == p.sport)) begin
        slot = i;
        break;
      end
    end
    if (slot >= 0) begin
      r.status = STATUS_HIT;
      r.back = (tbl_key[slot].src_addr != p.src_addr);
      tbl_pkts[slot] = sat_inc(tbl_pkts[slot]);
      if (p.tcp) begin
        if (r.back) tbl_bwd[slot] = sat_inc(tbl_bwd[slot]);
        else tbl_fwd[slot] = sat_inc(tbl_fwd[slot]);
      end
    end else if (tbl_used < ENTRIES) begin
      slot = tbl_used;
      r.status = STATUS_NEW;
      tbl_key[slot] = p;
      tbl_pkts[slot] = 1;
      tbl_fwd[slot] = 1;
      tbl_bwd[slot] = 0;
      tbl_used++;
    end else begin
      r.status = STATUS_FULL;
      return r;
    end
    r.slot = slot[5:0];
    r.pkts = tbl_pkts[slot][15:0];
    r.fwd = tbl_fwd[slot][15:0];
    r.bwd = tbl_bwd[slot][15:0];
    r.first_sec = tbl_key[slot].time_sec;
    r.first_usec = tbl_key[slot].time_usec;
    r.is_tcp = tbl_key[slot].tcp;
    return r;
  endfunction

  function automatic pkt_t rand_pkt();
    pkt_t p;
    p.tcp = $urandom_range(0, 1);
    p.src_addr = $urandom;
    p.dst_addr = $urandom;
    p.sport = $urandom;
    p.dport = $urandom;
    p.time_sec = $urandom;
    p.time_usec = $urandom;
    return p;
  endfunction

  function automatic pkt_t swap_dir(pkt_t p);
    pkt_t s;
    s = p;
    s.src_addr = p.dst_addr;
    s.dst_addr = p.src_addr;
    s.sport = p.dport;
    s.dport = p.sport;
    return s;
  endfunction

  // Driver: pops the next packet and offers it as a beat.
  always @(posedge clk) begin
    pkt_t p;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_q.push_back(flow_lookup(send_q.pop_front()));
      end
      if (!(in_tvalid && !in_tready)) begin
        if (send_q.size() > 0 && !hold_input &&
            (calm || $urandom_range(0, 99) >= 11)) begin
          p = send_q[0];
          in_tvalid <= 1'b1;
          in_tuser <= p.tcp;
          in_tdata <= {4'd0, p.time_usec, p.time_sec, p.dport, p.sport,
                       p.dst_addr, p.src_addr};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks result beats and drives random backpressure.
  always @(posedge clk) begin
    lookup_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.status     = out_tuser;
        got.slot       = out_tdata[5:0];
        got.back       = out_tdata[6];
        got.pkts       = out_tdata[22:7];
        got.fwd        = out_tdata[38:23];
        got.bwd        = out_tdata[54:39];
        got.first_sec  = out_tdata[86:55];
        got.first_usec = out_tdata[106:87];
        got.is_tcp     = out_tdata[107];
        results_seen++;
        if (got.status == STATUS_FULL) full_seen++;
        if (got.status == STATUS_HIT) hits_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected st=%0d slot=%0d bk=%0d pk=%0d f=%0d b=%0d",
                     $time, want.status, want.slot, want.back, want.pkts, want.fwd,
                     want.bwd);
            $display("%0t:          expected fs=%h fu=%h t=%0d", $time,
                     want.first_sec, want.first_usec, want.is_tcp);
            $display("%0t: mismatch actual   st=%0d slot=%0d bk=%0d pk=%0d f=%0d b=%0d",
                     $time, got.status, got.slot, got.back, got.pkts, got.fwd,
                     got.bwd);
            $display("%0t:          actual   fs=%h fu=%h t=%0d", $time,
                     got.first_sec, got.first_usec, got.is_tcp);
          end
        end
      end
      out_tready <= calm || ($urandom_range(0, 99) >= 11);
    end
  end

  // Stimulus.
  initial begin
    pkt_t p, base, flows[$];
    int n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, both directions, both protocols.
    p = '0;
    send_q.push_back(p);                     // all zero, new UDP flow
    send_q.push_back(p);                     // self-reverse tuple hit
    p = '1;
    send_q.push_back(p);                     // all ones, out-of-range usec
    p.tcp = 1'b0;
    send_q.push_back(p);                     // UDP hit on TCP entry
    base = rand_pkt();
    base.tcp = 1'b1;
    base.time_usec = 20'd999999;
    send_q.push_back(base);                  // new TCP flow
    send_q.push_back(base);                  // forward TCP hit
    p = swap_dir(base);
    send_q.push_back(p);                     // backward TCP hit
    p.tcp = 1'b0;
    send_q.push_back(p);                     // backward UDP hit
    p = base;
    p.sport = ~p.sport;
    send_q.push_back(p);                     // near miss, new flow
    p = rand_pkt();
    p.tcp = 1'b0;
    send_q.push_back(p);
    send_q.push_back(swap_dir(p));           // TCP-less reverse on UDP entry
    p.tcp = 1'b1;
    send_q.push_back(swap_dir(p));           // TCP packet on UDP entry

    // Let everything drain once before the random part.
    wait (send_q.size() == 0 && expected_q.size() == 0);
    hold_input = 1'b1;
    repeat (20) @(posedge clk);
    hold_input = 1'b0;

    // Repeated hits: one flow driven forward and back with no idling on
    // either side.
    calm = 1'b1;
    base = rand_pkt();
    base.tcp = 1'b1;
    for (int i = 0; i < 40; i++) begin
      p = (i % 2) ? swap_dir(base) : base;
      p.time_sec = i;
      send_q.push_back(p);
      if (send_q.size() > 16) wait (send_q.size() < 4);
    end
    wait (send_q.size() == 0);
    calm = 1'b0;

    // Random: mostly revisits of known flows, the rest fresh tuples, until
    // the table fills and drops appear.
    flows.push_back(base);
    for (int i = 0; i < 450; i++) begin
      n = $urandom_range(0, 99);
      if (n < 60) begin
        p = flows[$urandom_range(0, flows.size() - 1)];
        if ($urandom_range(0, 1)) p = swap_dir(p);
        p.tcp = $urandom_range(0, 1);
        p.time_sec = $urandom;
        p.time_usec = $urandom;
      end else begin
        p = rand_pkt();
        if ($urandom_range(0, 3) == 0) p.dst_addr = p.src_addr;
        if ($urandom_range(0, 3) == 0) p.time_usec = $urandom_range(0, 999999);
        flows.push_back(p);
      end
      send_q.push_back(p);
      calm = (i >= 200 && i < 260);
      if (send_q.size() > 8) wait (send_q.size() < 4);
    end
    calm = 1'b0;
    wait (send_q.size() == 0);
    stim_done = 1'b1;
  end

  // End of run.
  initial begin
    wait (stim_done);
    wait (expected_q.size() == 0 && !in_tvalid);
    repeat (40) @(posedge clk);
    $display("Checked %0d results: %0d hits, %0d drops on a full table,", results_seen,
             hits_seen, full_seen);
    $display("including long runs of hits on one flow in both directions.");
    if (errors == 0) begin
      $display("tb_bidirectional_flow_table: clean");
    end else begin
      $display("tb_bidirectional_flow_table: errors");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #20_000_000;
    $display("tb_bidirectional_flow_table: errors");
    $finish;
  end

endmodule
